>>> rtl/p2p_pkg.sv
// Package for the peak-to-peak level change reporter.
// Holds the shared sample, span and level types and the span to percent scaling.
// Depends on nothing.
`timescale 1ns / 1ps

package p2p_pkg;

  localparam int unsigned NumCh     = 3;
  localparam int unsigned SampleW   = 10;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned ProdW     = 17;
  localparam int unsigned FullScale = 1023;
  localparam int unsigned Percent   = 100;
  localparam int unsigned MinInit   = 1024;
  localparam int unsigned ThrReset  = 5;

  localparam int unsigned ChFront = 0;
  localparam int unsigned ChLeft  = 1;
  localparam int unsigned ChRight = 2;

  localparam logic CfgIdxEnable    = 1'b0;
  localparam logic CfgIdxThreshold = 1'b1;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [LevelW-1:0]  level_t;
  typedef logic [NumCh-1:0][SampleW-1:0] sample_vec_t;
  typedef logic [NumCh-1:0][LevelW-1:0]  level_vec_t;

  // Scales a span to span * 100 / 1023, truncated. The quotient estimate
  // product / 1024 is low by at most one, so one compare corrects it.
  function automatic level_t level_of(sample_t span);
    logic [ProdW-1:0]  prod;
    logic [LevelW-1:0] q0;
    logic [ProdW-1:0]  rem;
    prod = {{(ProdW-SampleW){1'b0}}, span} * ProdW'(Percent);
    q0   = prod[ProdW-1:SampleW];
    rem  = prod - {q0, {SampleW{1'b0}}} + {{(ProdW-LevelW){1'b0}}, q0};
    if (rem >= ProdW'(FullScale)) begin
      level_of = q0 + LevelW'(1);
    end else begin
      level_of = q0;
    end
  endfunction

endpackage

>>> rtl/p2p_in_if.sv
// Input channel of the level change reporter: one sample triple per word.
// Depends on p2p_pkg for the sample type.
`timescale 1ns / 1ps

interface p2p_in_if;
  logic              valid;
  logic              ready;
  p2p_pkg::sample_t  front_sample;
  p2p_pkg::sample_t  left_sample;
  p2p_pkg::sample_t  right_sample;

  modport source (output valid, output front_sample, output left_sample,
                  output right_sample, input ready);
  modport sink   (input valid, input front_sample, input left_sample,
                  input right_sample, output ready);
endinterface

>>> rtl/p2p_out_if.sv
// Output channel of the level change reporter: one level triple per word.
// Depends on p2p_pkg for the level type.
`timescale 1ns / 1ps

interface p2p_out_if;
  logic             valid;
  logic             ready;
  p2p_pkg::level_t  front_level;
  p2p_pkg::level_t  left_level;
  p2p_pkg::level_t  right_level;

  modport source (output valid, output front_level, output left_level,
                  output right_level, input ready);
  modport sink   (input valid, input front_level, input left_level,
                  input right_level, output ready);
endinterface

>>> rtl/p2p_window.sv
// Window tracker: per-channel minimum and maximum over WINDOW_LEN samples.
// Emits the three spans when a window closes. Depends on p2p_pkg.
`timescale 1ns / 1ps

module p2p_window #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 smp_valid_i,
  output logic                 smp_ready_o,
  input  p2p_pkg::sample_vec_t smp_data_i,
  output logic                 span_valid_o,
  input  logic                 span_ready_i,
  output p2p_pkg::sample_vec_t span_data_o
);
  import p2p_pkg::*;

  localparam int unsigned CntW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(WINDOW_LEN - 1);

  logic [NumCh-1:0][SampleW:0]   min_q, min_d;
  logic [NumCh-1:0][SampleW-1:0] max_q, max_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          span_valid_q, span_valid_d;
  sample_vec_t                   span_q, span_d;
  logic [NumCh-1:0][SampleW:0]   nmin;
  logic [NumCh-1:0][SampleW-1:0] nmax;
  logic                          accept;
  logic                          last;

  assign smp_ready_o  = !span_valid_q || span_ready_i;
  assign accept       = smp_valid_i && smp_ready_o;
  assign last         = (cnt_q == CntLast);
  assign span_valid_o = span_valid_q;
  assign span_data_o  = span_q;

  always_comb begin
    min_d        = min_q;
    max_d        = max_q;
    cnt_d        = cnt_q;
    span_d       = span_q;
    span_valid_d = span_valid_q && !span_ready_i;
    for (int c = 0; c < NumCh; c++) begin
      nmin[c] = ({1'b0, smp_data_i[c]} < min_q[c]) ? {1'b0, smp_data_i[c]} : min_q[c];
      nmax[c] = (smp_data_i[c] > max_q[c]) ? smp_data_i[c] : max_q[c];
    end
    if (accept) begin
      if (last) begin
        for (int c = 0; c < NumCh; c++) begin
          if ({1'b0, nmax[c]} >= nmin[c]) begin
            span_d[c] = SampleW'({1'b0, nmax[c]} - nmin[c]);
          end else begin
            span_d[c] = '0;
          end
          min_d[c] = (SampleW + 1)'(MinInit);
          max_d[c] = '0;
        end
        cnt_d        = '0;
        span_valid_d = 1'b1;
      end else begin
        min_d = nmin;
        max_d = nmax;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCh; c++) begin
        min_q[c] <= (SampleW + 1)'(MinInit);
        max_q[c] <= '0;
      end
      cnt_q        <= '0;
      span_valid_q <= 1'b0;
    end else begin
      min_q        <= min_d;
      max_q        <= max_d;
      cnt_q        <= cnt_d;
      span_valid_q <= span_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
  end

endmodule

>>> rtl/p2p_scale.sv
// Scaling stage: converts each span to a percentage of full scale.
// Depends on p2p_pkg for the types and the scaling function.
`timescale 1ns / 1ps

module p2p_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 span_valid_i,
  output logic                 span_ready_o,
  input  p2p_pkg::sample_vec_t span_data_i,
  output logic                 lvl_valid_o,
  input  logic                 lvl_ready_i,
  output p2p_pkg::level_vec_t  lvl_data_o
);
  import p2p_pkg::*;

  logic       lvl_valid_q;
  level_vec_t lvl_q, lvl_d;
  logic       accept;

  assign span_ready_o = !lvl_valid_q || lvl_ready_i;
  assign accept       = span_valid_i && span_ready_o;
  assign lvl_valid_o  = lvl_valid_q;
  assign lvl_data_o   = lvl_q;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      lvl_d[c] = level_of(span_data_i[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_valid_q <= 1'b0;
    end else if (accept) begin
      lvl_valid_q <= 1'b1;
    end else if (lvl_ready_i) begin
      lvl_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lvl_q <= lvl_d;
    end
  end

endmodule

>>> rtl/p2p_report.sv
// Report stage: compares new levels with the last reported ones against the
// threshold and holds the output register. Depends on p2p_pkg and p2p_out_if.
`timescale 1ns / 1ps

module p2p_report (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  p2p_pkg::level_t     threshold_i,
  input  logic                lvl_valid_i,
  output logic                lvl_ready_o,
  input  p2p_pkg::level_vec_t lvl_data_i,
  p2p_out_if.source           lvl_o
);
  import p2p_pkg::*;

  level_vec_t           ref_q;
  level_vec_t           out_q;
  logic                 out_valid_q;
  level_vec_t           diff;
  logic [NumCh-1:0]     over;
  logic                 changed;
  logic                 accept;

  assign lvl_ready_o       = !out_valid_q || lvl_o.ready;
  assign accept            = lvl_valid_i && lvl_ready_o;
  assign lvl_o.valid       = out_valid_q;
  assign lvl_o.front_level = out_q[ChFront];
  assign lvl_o.left_level  = out_q[ChLeft];
  assign lvl_o.right_level = out_q[ChRight];

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      diff[c] = (lvl_data_i[c] > ref_q[c]) ? (lvl_data_i[c] - ref_q[c])
                                           : (ref_q[c] - lvl_data_i[c]);
      over[c] = (diff[c] > threshold_i);
    end
    changed = |over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ref_q       <= '0;
    end else begin
      if (accept && changed) begin
        out_valid_q <= 1'b1;
        ref_q       <= lvl_data_i;
      end else if (lvl_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && changed) begin
      out_q <= lvl_data_i;
    end
  end

endmodule

>>> rtl/peak_to_peak_level_change_reporter_unit.sv
// Top level of the peak-to-peak level change reporter.
// Depends on p2p_pkg, p2p_in_if, p2p_out_if, p2p_window, p2p_scale, p2p_report.
//
//   Channel  Direction  Word                                  Handshake
//   smp_i    in         front, left, right sample (10 bits)   valid/ready
//   lvl_o    out        front, left, right level (7 bits)     valid/ready
//   cfg      in         enable (index 0), threshold (index 1) write enable only
//
// One sample word is taken per cycle while smp_i.ready is high; every stage is a
// single register with its own valid, so while a level word waits on lvl_o the
// input keeps flowing until two more windows have closed behind it, and then
// smp_i.ready drops. A report follows the sample closing its window through the
// input, span, level and output registers before it is valid on lvl_o.
// Reset clears the window, the reported levels and the stage valids; enable
// resets to 0 and the threshold to 5. Words taken while disabled are dropped.
`timescale 1ns / 1ps

module peak_to_peak_level_change_reporter_unit #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  p2p_pkg::level_t cfg_data_i,
  p2p_in_if.sink          smp_i,
  p2p_out_if.source       lvl_o
);
  import p2p_pkg::*;

  logic        enable_q;
  level_t      threshold_q;
  logic        a_valid_q;
  sample_vec_t a_data_q;
  logic        win_ready;
  logic        fire_in;
  logic        span_valid;
  logic        span_ready;
  sample_vec_t span_data;
  logic        lvl_valid;
  logic        lvl_ready;
  level_vec_t  lvl_data;

  assign smp_i.ready = !a_valid_q || win_ready;
  assign fire_in     = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      threshold_q <= LevelW'(ThrReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxEnable:    enable_q    <= cfg_data_i[0];
        CfgIdxThreshold: threshold_q <= cfg_data_i;
        default:         enable_q    <= enable_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (fire_in && enable_q) begin
      a_valid_q <= 1'b1;
    end else if (win_ready) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in && enable_q) begin
      a_data_q[ChFront] <= smp_i.front_sample;
      a_data_q[ChLeft]  <= smp_i.left_sample;
      a_data_q[ChRight] <= smp_i.right_sample;
    end
  end

  p2p_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_valid_i  (a_valid_q),
    .smp_ready_o  (win_ready),
    .smp_data_i   (a_data_q),
    .span_valid_o (span_valid),
    .span_ready_i (span_ready),
    .span_data_o  (span_data)
  );

  p2p_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .span_valid_i (span_valid),
    .span_ready_o (span_ready),
    .span_data_i  (span_data),
    .lvl_valid_o  (lvl_valid),
    .lvl_ready_i  (lvl_ready),
    .lvl_data_o   (lvl_data)
  );

  p2p_report u_report (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .lvl_valid_i (lvl_valid),
    .lvl_ready_o (lvl_ready),
    .lvl_data_i  (lvl_data),
    .lvl_o       (lvl_o)
  );

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_o.valid |-> (lvl_o.front_level <= LevelW'(Percent)) &&
                    (lvl_o.left_level <= LevelW'(Percent)) &&
                    (lvl_o.right_level <= LevelW'(Percent)))
    else $error("reported level above full scale");

  a_drop_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_in && !enable_q && !a_valid_q) |=> !a_valid_q)
    else $error("sample taken while disabled entered the window");

  a_scale_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_valid |-> (lvl_data[ChFront] <= LevelW'(Percent)) &&
                  (lvl_data[ChLeft] <= LevelW'(Percent)) &&
                  (lvl_data[ChRight] <= LevelW'(Percent)))
    else $error("scaled level above full scale");

endmodule
